// ===== sv/enhanced_clock_page_replacement_macros.svh =====
// Assertion macros shared by the page replacement RTL.
`ifndef ENHANCED_CLOCK_PAGE_REPLACEMENT_MACROS_SVH
`define ENHANCED_CLOCK_PAGE_REPLACEMENT_MACROS_SVH
// Consequent must hold in the same cycle as the antecedent.
`define ECPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ecpr same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define ECPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ecpr next-cycle check failed");
`endif

// ===== sv/ecpr_pkg.sv =====
// Shared types and constants for the enhanced clock page replacement block.
`timescale 1ns / 1ps
`default_nettype none
package ecpr_pkg;
	localparam int CFG_W   = 5;
	localparam int PAGE_W  = 16;
	localparam int FRAME_W = 4;
	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = 5'd4;

	typedef struct packed {
		logic load_in;
		logic norm;
		logic select;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic hand_ok;
		logic out_free;
	} status_t;
endpackage
`default_nettype wire

// ===== sv/enhanced_clock_page_replacement.sv =====
// Sequence: an accepted transaction steps through match, select and write; its result is
// registered on leaving write, which waits while the held result is stalled. No new transaction is
// taken until idle again; match holds while the hand is folded back after frames_in_use shrinks.
// Reset: arst_n clears the fill count, hand, referenced and modified bits and sets
// frames_in_use to 4; page tags hold no reset value and are read only after being written.
`timescale 1ns / 1ps
`default_nettype none
module enhanced_clock_page_replacement #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ecpr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ecpr_pkg::PAGE_W-1:0]  page,
	input  logic                         is_write,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic                         evicted,
	output logic [ecpr_pkg::PAGE_W-1:0]  evicted_page,
	output logic [ecpr_pkg::FRAME_W-1:0] frame
);
	ecpr_pkg::cmd_t    cmd;
	ecpr_pkg::status_t status;

	ecpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	ecpr_dp #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.page         (page),
		.is_write     (is_write),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.hit          (hit),
		.evicted      (evicted),
		.evicted_page (evicted_page),
		.frame        (frame)
	);
endmodule
`default_nettype wire

// ===== sv/ecpr_ctrl.sv =====
// Controller state machine sequencing match, select and write for each transaction.
`timescale 1ns / 1ps
`default_nettype none
`include "enhanced_clock_page_replacement_macros.svh"
module ecpr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ecpr_pkg::status_t status,
	output logic              in_stall,
	output ecpr_pkg::cmd_t    cmd
);
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MATCH  = 4'b0010,
		ST_SELECT = 4'b0100,
		ST_WRITE  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_MATCH;
				end
			end
			ST_MATCH: begin
				// stay here while the hand is folded back into range
				cmd.norm = 1'b1;
				if (status.hand_ok) begin
					state_d = ST_SELECT;
				end
			end
			ST_SELECT: begin
				cmd.select = 1'b1;
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				cmd.commit = status.out_free;
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	`ECPR_ASSERT_NOW(a_commit_needs_room, clk, arst_n, cmd.commit, status.out_free)
	`ECPR_ASSERT_NOW(a_state_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`ECPR_ASSERT_NEXT(a_accept_starts_match, clk, arst_n, in_valid && !in_stall, state_q == ST_MATCH)
endmodule
`default_nettype wire

// ===== sv/ecpr_dp.sv =====
// Datapath: frame table, match vectors, rotating victim search and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "enhanced_clock_page_replacement_macros.svh"
module ecpr_dp #(
	parameter int FRAMES    = 16,
	parameter int PAGE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ecpr_pkg::cmd_t               cmd,
	output ecpr_pkg::status_t            status,
	input  logic                         cfg_we,
	input  logic [ecpr_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic [ecpr_pkg::PAGE_W-1:0]  page,
	input  logic                         is_write,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic                         hit,
	output logic                         evicted,
	output logic [ecpr_pkg::PAGE_W-1:0]  evicted_page,
	output logic [ecpr_pkg::FRAME_W-1:0] frame
);
	localparam int CFG_W  = ecpr_pkg::CFG_W;
	localparam int PW     = ecpr_pkg::PAGE_W;
	localparam int FW     = ecpr_pkg::FRAME_W;
	localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef enum logic [1:0] {
		KIND_HIT   = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_EVICT = 2'd2
	} kind_t;

	// first set bit at or after h, wrapping to the lowest set bit
	function automatic logic [FIDX_W-1:0] first_from(input logic [FRAMES-1:0] v,
			input logic [FIDX_W-1:0] h);
		logic [FIDX_W-1:0] r_hi;
		logic [FIDX_W-1:0] r_lo;
		logic              f_hi;
		r_hi = '0;
		r_lo = '0;
		f_hi = 1'b0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (v[i]) begin
				r_lo = FIDX_W'(i);
				if (FIDX_W'(i) >= h) begin
					r_hi = FIDX_W'(i);
					f_hi = 1'b1;
				end
			end
		end
		return f_hi ? r_hi : r_lo;
	endfunction

	logic [CFG_W-1:0]     cfg_q;
	logic [PAGE_BITS-1:0] pg_q;
	logic                 wr_q;
	logic [PAGE_BITS-1:0] tag_q [FRAMES];
	logic [FRAMES-1:0]    ref_q;
	logic [FRAMES-1:0]    mod_q;
	logic [CNT_W-1:0]     filled_q;
	logic [FIDX_W-1:0]    hand_q;

	logic [CNT_W-1:0]     w_eff;
	logic [CNT_W-1:0]     hand_ext;
	logic                 hand_ok;
	logic [FRAMES-1:0]    act_m;
	logic [FRAMES-1:0]    hit_vec;
	logic [CMP_W-1:0]     cfg_ext;

	logic [FRAMES-1:0]    hit_vec_s1;
	logic [FRAMES-1:0]    c1_s1;
	logic [FRAMES-1:0]    c2_s1;
	logic [FRAMES-1:0]    c3_s1;
	logic                 full_s1;

	kind_t                kind_d;
	logic [FIDX_W-1:0]    idx_d;
	logic [FRAMES-1:0]    clr_d;
	logic [FIDX_W-1:0]    c2_idx;

	kind_t                kind_s2;
	logic [FIDX_W-1:0]    frame_s2;
	logic [FRAMES-1:0]    clr_s2;

	logic [FRAMES-1:0]    sel_oh;
	logic [FRAMES-1:0]    wr_oh;
	logic [PAGE_BITS-1:0] old_tag;

	logic                 out_valid_q;
	logic                 hit_q;
	logic                 evicted_q;
	logic [PW-1:0]        evicted_page_q;
	logic [FW-1:0]        frame_q;

	// active frame count: zero acts as one, clamp to table size
	assign cfg_ext  = CMP_W'(cfg_q);
	assign w_eff    = (cfg_q == '0) ? CNT_W'(1) :
		((cfg_ext > CMP_W'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(cfg_ext));
	assign hand_ext = CNT_W'(hand_q);
	assign hand_ok  = (hand_ext < w_eff);

	always_comb begin
		for (int t = 0; t < FRAMES; t++) begin
			act_m[t]   = (CNT_W'(t) < w_eff);
			hit_vec[t] = act_m[t] && (CNT_W'(t) < filled_q) && (tag_q[t] == pg_q);
		end
	end

	// victim choice from the registered match vectors
	assign c2_idx = first_from(c2_s1, hand_q);

	always_comb begin
		kind_d = KIND_EVICT;
		idx_d  = hand_q;
		clr_d  = '0;
		priority if (|hit_vec_s1) begin
			kind_d = KIND_HIT;
			idx_d  = first_from(hit_vec_s1, hand_q);
		end else if (!full_s1) begin
			kind_d = KIND_FILL;
			idx_d  = FIDX_W'(filled_q);
		end else if (|c1_s1) begin
			idx_d = first_from(c1_s1, hand_q);
		end else if (|c2_s1) begin
			idx_d = c2_idx;
			// clear frames passed between the hand and the victim
			for (int t = 0; t < FRAMES; t++) begin
				if (c2_idx >= hand_q) begin
					clr_d[t] = act_m[t] && (FIDX_W'(t) >= hand_q) && (FIDX_W'(t) < c2_idx);
				end else begin
					clr_d[t] = act_m[t] && ((FIDX_W'(t) >= hand_q) || (FIDX_W'(t) < c2_idx));
				end
			end
		end else begin
			// a full second pass clears every active frame's referenced bit, then retry
			clr_d = act_m;
			if (|c3_s1) begin
				idx_d = first_from(c3_s1, hand_q);
			end
		end
	end

	always_comb begin
		for (int t = 0; t < FRAMES; t++) begin
			sel_oh[t] = (frame_s2 == FIDX_W'(t));
		end
		wr_oh = wr_q ? sel_oh : '0;
	end

	assign old_tag = tag_q[frame_s2];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pg_q <= PAGE_BITS'(page);
			wr_q <= is_write;
		end
		if (cmd.norm) begin
			hit_vec_s1 <= hit_vec;
			c1_s1      <= act_m & ~ref_q & ~mod_q;
			c2_s1      <= act_m & ~ref_q & mod_q;
			c3_s1      <= act_m & ~mod_q;
			full_s1    <= (filled_q >= w_eff);
		end
		if (cmd.select) begin
			kind_s2  <= kind_d;
			frame_s2 <= idx_d;
			clr_s2   <= clr_d;
		end
		if (cmd.commit) begin
			if (kind_s2 != KIND_HIT) begin
				tag_q[frame_s2] <= pg_q;
			end
			hit_q          <= (kind_s2 == KIND_HIT);
			evicted_q      <= (kind_s2 == KIND_EVICT);
			evicted_page_q <= (kind_s2 == KIND_EVICT) ? PW'(old_tag) : '0;
			frame_q        <= FW'(frame_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= ecpr_pkg::FRAMES_IN_USE_RESET;
			ref_q       <= '0;
			mod_q       <= '0;
			filled_q    <= '0;
			hand_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.norm && !hand_ok) begin
				hand_q <= FIDX_W'(hand_ext - w_eff);
			end
			if (cmd.commit) begin
				ref_q  <= (ref_q & ~clr_s2) | sel_oh;
				hand_q <= frame_s2;
				if (kind_s2 == KIND_HIT) begin
					mod_q <= mod_q | wr_oh;
				end else begin
					mod_q <= (mod_q & ~sel_oh) | wr_oh;
				end
				if (kind_s2 == KIND_FILL) begin
					filled_q <= filled_q + CNT_W'(1);
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.hand_ok  = hand_ok;
	assign status.out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign evicted      = evicted_q;
	assign evicted_page = evicted_page_q;
	assign frame        = frame_q;

	`ECPR_ASSERT_NOW(a_hit_frame_matches, clk, arst_n, cmd.commit && (kind_s2 == KIND_HIT), hit_vec_s1[frame_s2])
	`ECPR_ASSERT_NEXT(a_ref_set_after_commit, clk, arst_n, cmd.commit, ref_q[$past(frame_s2)])
	`ECPR_ASSERT_NOW(a_fill_bound, clk, arst_n, 1'b1, filled_q <= CNT_W'(FRAMES))
endmodule
`default_nettype wire
